// File: rtl/core/sha1_pkg.sv
// sha1_pkg: shared types, constants and round functions of the sha-1 hash unit
// used by sha1_compress and sha1_hash_unit; no dependencies
package sha1_pkg;

  localparam int unsigned HashWords   = 5;
  localparam int unsigned WindowDepth = 16;
  localparam int unsigned Rounds      = 80;
  localparam int unsigned RoundW      = $clog2(Rounds);
  localparam int unsigned HashIdxW    = $clog2(HashWords);
  localparam int unsigned ByteCountW  = 61;
  localparam int unsigned WordCountW  = $clog2(WindowDepth) + 1;

  typedef logic [31:0] word_t;

  localparam word_t InitH [HashWords] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam word_t PadByteWord = 32'h80000000;

  typedef struct packed {
    logic  push;
    word_t word;
    logic  start;
    logic  restart;
  } sha1_cmd_t;

  function automatic word_t round_k(input logic [RoundW-1:0] t);
    word_t k;
    if (t < RoundW'(20)) begin
      k = K0;
    end else if (t < RoundW'(40)) begin
      k = K1;
    end else if (t < RoundW'(60)) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

  function automatic word_t round_f(input logic [RoundW-1:0] t, input word_t b,
                                    input word_t c, input word_t d);
    word_t f;
    if (t < RoundW'(20)) begin
      f = (b & c) | (~b & d);
    end else if (t < RoundW'(40)) begin
      f = b ^ c ^ d;
    end else if (t < RoundW'(60)) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

// File: rtl/core/sha1_in_if.sv
// sha1_in_if: valid/ready channel carrying one message byte beat
// depends on nothing
interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output has_byte,
                  output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input has_byte,
                  input end_of_message, output ready);
endinterface

// File: rtl/core/sha1_out_if.sv
// sha1_out_if: valid/ready channel carrying one digest word beat
// depends on nothing
interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        last_word;

  modport source (output valid, output digest_word, output last_word, input ready);
  modport sink   (input valid, input digest_word, input last_word, output ready);
endinterface

// File: rtl/core/sha1_hash_unit.sv
// sha1_hash_unit: sha-1 over a byte stream with padding and digest readout
// depends on sha1_pkg, sha1_in_if, sha1_out_if and sha1_compress
//
//   channel     dir  payload                               last beat
//   msg_in      in   data_byte, has_byte, end_of_message   end_of_message
//   digest_out  out  digest_word, last_word                last_word
//
// a byte beat is accepted while idle; a beat that fills a 64-byte block
// holds msg_in.ready low while the shared round unit runs
// 80 rounds and the chaining add, one round per cycle
// end of message adds padding (over two blocks when the length
// spills into a second block), one or two compressions and five digest beats;
// digest_out stalls simply hold the current word
// rst is synchronous and restores the initial chaining value and a zero count
module sha1_hash_unit (
  input  logic        clk,
  input  logic        rst,
  sha1_in_if.sink     msg_in,
  sha1_out_if.source  digest_out
);

  typedef enum logic [2:0] {
    S_IDLE, S_COMP, S_PAD, S_ZERO, S_LEN_HI, S_LEN_LO, S_OUT
  } state_t;

  localparam logic [sha1_pkg::HashIdxW-1:0] LastIdx =
    sha1_pkg::HashIdxW'(sha1_pkg::HashWords - 1);
  localparam logic [sha1_pkg::WordCountW-1:0] FullWords =
    sha1_pkg::WordCountW'(sha1_pkg::WindowDepth);
  localparam logic [sha1_pkg::WordCountW-1:0] LenWordPos =
    sha1_pkg::WordCountW'(sha1_pkg::WindowDepth - 2);

  state_t                              state;
  state_t                              ret;
  logic [sha1_pkg::ByteCountW-1:0]     count;
  logic [sha1_pkg::WordCountW-1:0]     wc;
  logic [sha1_pkg::HashIdxW-1:0]       oidx;
  logic [23:0]                         acc;
  logic                                accept;
  logic                                take_byte;
  logic                                word_done;
  logic                                block_done;
  sha1_pkg::word_t                     pad_word;
  sha1_pkg::sha1_cmd_t                 cmd;
  logic                                busy;
  sha1_pkg::word_t                     hash [sha1_pkg::HashWords];

  sha1_compress u_compress (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .busy (busy),
    .hash (hash)
  );

  assign msg_in.ready           = (state == S_IDLE);
  assign accept                 = msg_in.valid & msg_in.ready;
  assign take_byte              = accept & msg_in.has_byte;
  assign word_done              = (count[1:0] == 2'd3);
  assign block_done             = (count[5:0] == 6'd63);
  assign digest_out.valid       = (state == S_OUT);
  assign digest_out.digest_word = hash[oidx];
  assign digest_out.last_word   = (oidx == LastIdx);

  always_comb begin
    case (count[1:0])
      2'd1:    pad_word = {acc[7:0], 8'h80, 16'h0000};
      2'd2:    pad_word = {acc[15:0], 8'h80, 8'h00};
      2'd3:    pad_word = {acc[23:0], 8'h80};
      default: pad_word = sha1_pkg::PadByteWord;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (take_byte && word_done) begin
          cmd.push = 1'b1;
          cmd.word = {acc, msg_in.data_byte};
        end
        if (take_byte && block_done) begin
          cmd.start = 1'b1;
        end
      end
      S_PAD: begin
        cmd.push = 1'b1;
        cmd.word = pad_word;
      end
      S_ZERO: begin
        if (wc == FullWords) begin
          cmd.start = 1'b1;
        end else if (wc != LenWordPos) begin
          cmd.push = 1'b1;
        end
      end
      S_LEN_HI: begin
        cmd.push = 1'b1;
        cmd.word = count[60:29];
      end
      S_LEN_LO: begin
        cmd.push  = 1'b1;
        cmd.word  = {count[28:0], 3'b000};
        cmd.start = 1'b1;
      end
      S_OUT: begin
        cmd.restart = digest_out.ready && (oidx == LastIdx);
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
      count <= '0;
      wc    <= '0;
      oidx  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (take_byte) begin
              count <= count + 1'b1;
              if (word_done) begin
                wc <= wc + 1'b1;
              end
            end
            if (take_byte && block_done) begin
              wc    <= '0;
              state <= S_COMP;
              ret   <= msg_in.end_of_message ? S_PAD : S_IDLE;
            end else if (msg_in.end_of_message) begin
              state <= S_PAD;
            end
          end
        end
        S_COMP: begin
          if (!busy) begin
            state <= ret;
          end
        end
        S_PAD: begin
          wc    <= wc + 1'b1;
          state <= S_ZERO;
        end
        S_ZERO: begin
          if (wc == FullWords) begin
            wc    <= '0;
            state <= S_COMP;
            ret   <= S_ZERO;
          end else if (wc == LenWordPos) begin
            state <= S_LEN_HI;
          end else begin
            wc <= wc + 1'b1;
          end
        end
        S_LEN_HI: begin
          wc    <= wc + 1'b1;
          state <= S_LEN_LO;
        end
        S_LEN_LO: begin
          wc    <= '0;
          oidx  <= '0;
          state <= S_COMP;
          ret   <= S_OUT;
        end
        S_OUT: begin
          if (digest_out.ready) begin
            if (oidx == LastIdx) begin
              count <= '0;
              wc    <= '0;
              oidx  <= '0;
              state <= S_IDLE;
            end else begin
              oidx <= oidx + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // partial word, last three bytes
  always_ff @(posedge clk) begin
    if (take_byte) begin
      acc <= {acc[15:0], msg_in.data_byte};
    end
  end

`ifndef SYNTHESIS
  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    accept |-> !busy)
    else $error("beat accepted while round unit busy");

  a_word_count_bound: assert property (@(posedge clk) disable iff (rst)
    wc <= FullWords)
    else $error("schedule word count overflow");

  a_ready_after_last: assert property (@(posedge clk) disable iff (rst)
    digest_out.valid && digest_out.ready && digest_out.last_word |=> msg_in.ready)
    else $error("not ready after final digest beat");

  a_start_only_when_full: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> (wc == FullWords) || (state == S_LEN_LO) || (take_byte && block_done))
    else $error("compression started on a partial block");
`endif

endmodule

// File: rtl/core/sha1_compress.sv
// sha1_compress: 16-word schedule window, chaining value and one round per cycle
// depends on sha1_pkg
module sha1_compress (
  input  logic                  clk,
  input  logic                  rst,
  input  sha1_pkg::sha1_cmd_t   cmd,
  output logic                  busy,
  output sha1_pkg::word_t       hash [sha1_pkg::HashWords]
);

  typedef enum logic [1:0] {C_IDLE, C_ROUND, C_ADD} cstate_t;

  cstate_t                       state;
  logic [sha1_pkg::RoundW-1:0]   rnd;
  sha1_pkg::word_t               a, b, c, d, e;
  sha1_pkg::word_t               win [sha1_pkg::WindowDepth];
  sha1_pkg::word_t               w_mix;
  sha1_pkg::word_t               w_new;
  sha1_pkg::word_t               tmp;

  assign busy  = (state != C_IDLE);
  assign w_mix = win[13] ^ win[8] ^ win[2] ^ win[0];
  assign w_new = {w_mix[30:0], w_mix[31]};
  assign tmp   = {a[26:0], a[31:27]} + sha1_pkg::round_f(rnd, b, c, d) + e
               + sha1_pkg::round_k(rnd) + win[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      rnd   <= '0;
      for (int i = 0; i < sha1_pkg::HashWords; i++) begin
        hash[i] <= sha1_pkg::InitH[i];
      end
    end else begin
      unique case (state)
        C_IDLE: begin
          if (cmd.start) begin
            rnd   <= '0;
            state <= C_ROUND;
          end
          if (cmd.restart) begin
            for (int i = 0; i < sha1_pkg::HashWords; i++) begin
              hash[i] <= sha1_pkg::InitH[i];
            end
          end
        end
        C_ROUND: begin
          rnd <= rnd + 1'b1;
          if (rnd == sha1_pkg::RoundW'(sha1_pkg::Rounds - 1)) begin
            state <= C_ADD;
          end
        end
        C_ADD: begin
          hash[0] <= hash[0] + a;
          hash[1] <= hash[1] + b;
          hash[2] <= hash[2] + c;
          hash[3] <= hash[3] + d;
          hash[4] <= hash[4] + e;
          state   <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  // schedule window and working variables
  always_ff @(posedge clk) begin
    if (state == C_ROUND) begin
      for (int i = 0; i < sha1_pkg::WindowDepth - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[sha1_pkg::WindowDepth-1] <= w_new;
      a <= tmp;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end else if (state == C_IDLE) begin
      if (cmd.push) begin
        for (int i = 0; i < sha1_pkg::WindowDepth - 1; i++) begin
          win[i] <= win[i+1];
        end
        win[sha1_pkg::WindowDepth-1] <= cmd.word;
      end
      if (cmd.start) begin
        a <= hash[0];
        b <= hash[1];
        c <= hash[2];
        d <= hash[3];
        e <= hash[4];
      end
    end
  end

endmodule

// File: tb/sha1_hash_unit_tb.sv
`timescale 1ns / 1ps
// sha1_hash_unit_tb: self-checking bench for sha1_hash_unit, with bursty byte beats in and
// stalled digest beats out, checked against a sha-1 predictor kept inside the bench
// depends on sha1_pkg, sha1_in_if, sha1_out_if and the sha1_hash_unit rtl
module sha1_hash_unit_tb;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned HoldCycles = 500;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } msg_beat_t;

  typedef struct packed {
    sha1_pkg::word_t word;
    logic            last;
  } digest_beat_t;

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SLOW, RX_MOSTLY} rx_mode_t;

  logic clk;
  logic rst;

  sha1_in_if  msg_in ();
  sha1_out_if digest_out ();

  sha1_hash_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .msg_in     (msg_in),
    .digest_out (digest_out)
  );

  msg_beat_t    pending_beats[$];
  digest_beat_t digests_due[$];

  sha1_pkg::word_t chain_words [5];
  sha1_pkg::word_t block_words [16];
  logic [60:0]     byte_count;

  int unsigned error_count;
  int unsigned beats_queued;
  int unsigned beats_accepted;
  int unsigned counted_beats;
  int unsigned cycle_count;
  int          burst_left;
  int          gap_left;
  int          rx_mode_left;
  rx_mode_t    rx_mode;
  int unsigned rx_hold_left;
  logic        hold_used;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  task automatic report_mismatch(input string what, input sha1_pkg::word_t got,
                                 input sha1_pkg::word_t want);
    $display("%0t ERROR %s: got %08h, want %08h", $time, what, got, want);
    error_count++;
  endtask

  function automatic sha1_pkg::word_t rotl(input sha1_pkg::word_t v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  task automatic restart_digest();
    chain_words[0] = 32'h67452301;
    chain_words[1] = 32'hEFCDAB89;
    chain_words[2] = 32'h98BADCFE;
    chain_words[3] = 32'h10325476;
    chain_words[4] = 32'hC3D2E1F0;
    byte_count     = '0;
  endtask

  task automatic compress_block();
    sha1_pkg::word_t w [16];
    sha1_pkg::word_t a, b, c, d, e, f, k, wt, tmp;
    for (int i = 0; i < 16; i++) w[i] = block_words[i];
    a = chain_words[0];
    b = chain_words[1];
    c = chain_words[2];
    d = chain_words[3];
    e = chain_words[4];
    for (int t = 0; t < 80; t++) begin
      if (t >= 16) begin
        wt = rotl(w[(t - 3) & 15] ^ w[(t - 8) & 15] ^ w[(t - 14) & 15] ^ w[t & 15], 1);
        w[t & 15] = wt;
      end else begin
        wt = w[t];
      end
      case (t / 20)
        0: begin
          f = (b & c) | (~b & d);
          k = 32'h5A827999;
        end
        1: begin
          f = b ^ c ^ d;
          k = 32'h6ED9EBA1;
        end
        2: begin
          f = (b & c) | (b & d) | (c & d);
          k = 32'h8F1BBCDC;
        end
        default: begin
          f = b ^ c ^ d;
          k = 32'hCA62C1D6;
        end
      endcase
      tmp = rotl(a, 5) + f + e + k + wt;
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = tmp;
    end
    chain_words[0] += a;
    chain_words[1] += b;
    chain_words[2] += c;
    chain_words[3] += d;
    chain_words[4] += e;
  endtask

  task automatic predict_digest(input msg_beat_t beat);
    int              p;
    int              sh;
    sha1_pkg::word_t keep;
    logic [63:0]     bit_len;
    digest_beat_t    db;
    if (beat.has_byte) begin
      p  = int'(byte_count[5:0]);
      sh = 24 - 8 * (p & 3);
      if ((p & 3) == 0) block_words[p >> 2] = sha1_pkg::word_t'(beat.data_byte) << sh;
      else block_words[p >> 2] |= sha1_pkg::word_t'(beat.data_byte) << sh;
      byte_count = byte_count + 61'd1;
      if (byte_count[5:0] == 6'd0) compress_block();
    end
    if (beat.end_of_message) begin
      p       = int'(byte_count[5:0]);
      sh      = 24 - 8 * (p & 3);
      keep    = ((p & 3) == 0) ? 32'h0 : (32'hFFFFFFFF << (sh + 8));
      bit_len = {byte_count, 3'b000};
      block_words[p >> 2] = (block_words[p >> 2] & keep) | (32'h80 << sh);
      for (int i = (p >> 2) + 1; i < 16; i++) block_words[i] = '0;
      if (p >= 56) begin
        compress_block();
        for (int i = 0; i < 16; i++) block_words[i] = '0;
      end
      block_words[14] = bit_len[63:32];
      block_words[15] = bit_len[31:0];
      compress_block();
      for (int i = 0; i < 5; i++) begin
        db.word = chain_words[i];
        db.last = (i == 4);
        digests_due.push_back(db);
      end
      restart_digest();
    end
  endtask

  task automatic queue_beat(input logic [7:0] data, input logic has, input logic eom);
    msg_beat_t beat;
    beat.data_byte      = data;
    beat.has_byte       = has;
    beat.end_of_message = eom;
    pending_beats.push_back(beat);
    beats_queued++;
    if (has || eom) counted_beats++;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // random content, idle beats sprinkled in, end either on the last byte or on its own
  task automatic queue_message(input int len);
    logic end_on_byte;
    end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 11) == 0) queue_beat(8'($urandom), 1'b0, 1'b0);
      queue_beat(pick_byte(), 1'b1, end_on_byte && (i == len - 1));
    end
    if (!end_on_byte) queue_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic pick_burst();
    if ($urandom_range(0, 7) == 0) begin
      burst_left = $urandom_range(60, 200);
      gap_left   = 0;
    end else begin
      burst_left = $urandom_range(1, 20);
      gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
    end
  endtask

  initial begin
    int          len;
    int unsigned edge_lens [8];
    edge_lens = '{55, 56, 57, 63, 64, 65, 119, 120};
    rst                       = 1'b1;
    msg_in.valid              = 1'b0;
    msg_in.data_byte          = 8'h00;
    msg_in.has_byte           = 1'b0;
    msg_in.end_of_message     = 1'b0;
    digest_out.ready          = 1'b0;
    error_count               = 0;
    beats_queued              = 0;
    beats_accepted            = 0;
    counted_beats             = 0;
    restart_digest();
    for (int i = 0; i < 16; i++) block_words[i] = '0;

    // empty message, then one byte with end on the same beat
    queue_beat(8'hA5, 1'b0, 1'b1);
    queue_beat(8'hFF, 1'b1, 1'b1);
    // "abc" with an idle beat in the middle
    queue_beat(8'h61, 1'b1, 1'b0);
    queue_beat(8'h5A, 1'b0, 1'b0);
    queue_beat(8'h62, 1'b1, 1'b0);
    queue_beat(8'h63, 1'b1, 1'b1);
    // byte extremes, end on its own beat
    queue_beat(8'h00, 1'b1, 1'b0);
    queue_beat(8'hFF, 1'b1, 1'b0);
    queue_beat(8'h80, 1'b1, 1'b0);
    queue_beat(8'h7F, 1'b1, 1'b0);
    queue_beat(8'hFF, 1'b0, 1'b1);
    queue_beat(8'h00, 1'b0, 1'b1);

    // padding edges first: length field fits, just misses, full block
    queue_message(55);
    queue_message(56);
    queue_message(64);
    while (counted_beats < 450) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: len = $urandom_range(0, 12);
        5, 6, 7:       len = edge_lens[$urandom_range(0, 7)];
        default:       len = $urandom_range(0, 130);
      endcase
      queue_message(len);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (beats_accepted != beats_queued || digests_due.size() != 0);
    repeat (200) @(negedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  always @(posedge clk) begin : driver
    msg_beat_t nxt;
    if (rst) begin
      msg_in.valid <= 1'b0;
      pick_burst();
    end else begin
      if (msg_in.valid && msg_in.ready) begin
        nxt.data_byte      = msg_in.data_byte;
        nxt.has_byte       = msg_in.has_byte;
        nxt.end_of_message = msg_in.end_of_message;
        predict_digest(nxt);
        beats_accepted++;
      end
      if (!msg_in.valid || msg_in.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          msg_in.valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          nxt = pending_beats.pop_front();
          msg_in.valid          <= 1'b1;
          msg_in.data_byte      <= nxt.data_byte;
          msg_in.has_byte       <= nxt.has_byte;
          msg_in.end_of_message <= nxt.end_of_message;
          burst_left--;
          if (burst_left <= 0) pick_burst();
        end else begin
          msg_in.valid <= 1'b0;
        end
      end
    end
  end

  // one long hold-off on the digest side so the unit backs up onto its input
  always @(posedge clk) begin
    if (rst) begin
      rx_hold_left <= 0;
      hold_used    <= 1'b0;
    end else if (!hold_used && beats_accepted >= 100 && digest_out.valid) begin
      rx_hold_left <= HoldCycles;
      hold_used    <= 1'b1;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  always @(posedge clk) begin : monitor
    digest_beat_t want;
    if (rst) begin
      digest_out.ready <= 1'b0;
      rx_mode          = RX_FREE;
      rx_mode_left     = 0;
    end else begin
      if (digest_out.valid && digest_out.ready) begin
        if (digests_due.size() == 0) begin
          report_mismatch("digest beat with none due", digest_out.digest_word, '0);
        end else begin
          want = digests_due.pop_front();
          if (digest_out.digest_word !== want.word)
            report_mismatch("digest_word", digest_out.digest_word, want.word);
          if (digest_out.last_word !== want.last)
            report_mismatch("last_word", sha1_pkg::word_t'(digest_out.last_word),
                            sha1_pkg::word_t'(want.last));
        end
      end
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_t'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(16, 160);
      end else begin
        rx_mode_left--;
      end
      if (rx_hold_left != 0) begin
        digest_out.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_FREE:   digest_out.ready <= 1'b1;
          RX_COIN:   digest_out.ready <= ($urandom_range(0, 1) == 1);
          RX_SLOW:   digest_out.ready <= ($urandom_range(0, 3) == 0);
          default:   digest_out.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t ERROR timeout after %0d cycles", $time, CycleLimit);
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

// File: files.f
rtl/core/sha1_pkg.sv
rtl/core/sha1_in_if.sv
rtl/core/sha1_out_if.sv
rtl/core/sha1_compress.sv
rtl/core/sha1_hash_unit.sv
tb/sha1_hash_unit_tb.sv
